/* design/utf8_bigram_span_tokenizer_assert.svh */
// Assertion macros for the UTF-8 bigram span tokenizer
`ifndef UTF8_BIGRAM_SPAN_TOKENIZER_ASSERT_SVH
`define UTF8_BIGRAM_SPAN_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UBST_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tokenizer assertion failed");
`define UBST_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("tokenizer assertion failed");
`else
`define UBST_ASSERT(label, clk, rst_n, prop)
`define UBST_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* design/ubst_pkg.sv */
// Shared types, constants and helpers of the UTF-8 bigram span tokenizer
`timescale 1ns / 1ps
package ubst_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ASCII_HI = 8'h7f;
	localparam logic [7:0] LEAD2_LO = 8'hc2;
	localparam logic [7:0] LEAD2_HI = 8'hdf;
	localparam logic [7:0] LEAD3_LO = 8'he0;
	localparam logic [7:0] LEAD3_HI = 8'hef;
	localparam logic [7:0] LEAD4_LO = 8'hf0;
	localparam logic [7:0] LEAD4_HI = 8'hf4;
	localparam logic [7:0] LEAD_E0  = 8'he0;
	localparam logic [7:0] LEAD_ED  = 8'hed;
	localparam logic [7:0] LEAD_F0  = 8'hf0;
	localparam logic [7:0] LEAD_F4  = 8'hf4;
	localparam logic [7:0] CONT_LO  = 8'h80;
	localparam logic [7:0] CONT_HI  = 8'hbf;
	localparam logic [7:0] E0_LO    = 8'ha0;
	localparam logic [7:0] ED_HI    = 8'h9f;
	localparam logic [7:0] F0_LO    = 8'h90;
	localparam logic [7:0] F4_HI    = 8'h8f;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		KIND_TOKEN  = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} text_word_t;

	typedef struct packed {
		kind_t       item_kind;
		logic [31:0] span_start;
		logic [31:0] span_end;
		logic [31:0] bigram_index;
		status_t     text_status;
		logic        final_item;
	} token_word_t;

	typedef struct packed {
		logic [1:0] count;
	} push_t;

	function automatic logic cont_ok(input logic [7:0] b, input logic [1:0] seq,
			input logic [7:0] lead);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_LO;
		hi = CONT_HI;
		if (seq == 2'd0) begin
			case (lead)
				LEAD_E0: lo = E0_LO;
				LEAD_ED: hi = ED_HI;
				LEAD_F0: lo = F0_LO;
				LEAD_F4: hi = F4_HI;
				default: ;
			endcase
		end
		return (b >= lo) && (b <= hi);
	endfunction

endpackage

/* design/ubst_core.sv */
// Input register, UTF-8 validation, offset tracking and token generation
`timescale 1ns / 1ps
`include "utf8_bigram_span_tokenizer_assert.svh"
module ubst_core #(
	parameter int OFFSET_BITS = ubst_pkg::OFFSET_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      text_valid,
	output logic                      text_stall,
	input  ubst_pkg::text_word_t      text_word,
	input  logic                      room,
	output ubst_pkg::push_t           push,
	output ubst_pkg::token_word_t     res0,
	output ubst_pkg::token_word_t     res1
);
	import ubst_pkg::*;

	logic                   valid_s1;
	text_word_t             word_s1;
	logic                   go;

	logic [OFFSET_BITS-1:0] off_q, prev_q, cur_q;
	logic [1:0]             pend_q, seq_q;
	logic [7:0]             lead_q;
	logic                   have_q;
	logic [31:0]            cnt_q;
	status_t                err_q;

	logic [OFFSET_BITS-1:0] off_d, prev_d, cur_d, end_off;
	logic [1:0]             pend_d, seq_d;
	logic [7:0]             lead_d;
	logic                   have_d;
	logic [31:0]            cnt_d;
	status_t                err_d;
	status_t                final_st;
	logic                   complete;
	logic                   tok;
	logic [7:0]             b;

	token_word_t            tok_word, st_word;

	assign go         = valid_s1 && room;
	assign text_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			word_s1 <= text_word;
		end
	end

	assign b       = word_s1.data_byte;
	assign end_off = off_q + OFFSET_BITS'(1);

	always_comb begin
		off_d    = off_q;
		prev_d   = prev_q;
		cur_d    = cur_q;
		pend_d   = pend_q;
		seq_d    = seq_q;
		lead_d   = lead_q;
		have_d   = have_q;
		cnt_d    = cnt_q;
		err_d    = err_q;
		complete = 1'b0;
		tok      = 1'b0;
		if (err_q == ST_OK) begin
			if (off_q == '1) begin
				err_d = ST_OVERFLOW;
			end else begin
				if (pend_q == 2'd0) begin
					cur_d  = off_q;
					lead_d = b;
					seq_d  = 2'd0;
					if (b <= ASCII_HI) begin
						complete = 1'b1;
					end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
						pend_d = 2'd1;
					end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
						pend_d = 2'd2;
					end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
						pend_d = 2'd3;
					end else begin
						err_d = ST_INVALID;
					end
				end else if (cont_ok(b, seq_q, lead_q)) begin
					pend_d = pend_q - 2'd1;
					seq_d  = seq_q + 2'd1;
					complete = (pend_q == 2'd1);
				end else begin
					err_d = ST_INVALID;
				end
				if (err_d == ST_OK) begin
					if (complete) begin
						if (have_q) begin
							tok = 1'b1;
							if (cnt_q == '1) begin
								err_d = ST_OVERFLOW;
							end else begin
								cnt_d = cnt_q + 32'd1;
							end
						end
						prev_d = cur_d;
						have_d = 1'b1;
					end
					off_d = end_off;
				end
			end
		end
		final_st = err_d;
		if (final_st == ST_OK && pend_d != 2'd0) begin
			final_st = ST_INVALID;
		end
	end

	always_comb begin
		tok_word              = '0;
		tok_word.item_kind    = KIND_TOKEN;
		tok_word.span_start   = 32'(prev_q);
		tok_word.span_end     = 32'(end_off);
		tok_word.bigram_index = cnt_q;
		tok_word.text_status  = ST_OK;
		tok_word.final_item   = 1'b0;

		st_word             = '0;
		st_word.item_kind   = KIND_STATUS;
		st_word.text_status = final_st;
		st_word.final_item  = 1'b1;

		res0       = tok ? tok_word : st_word;
		res1       = st_word;
		push.count = 2'd0;
		if (go) begin
			push.count = 2'(tok) + 2'(word_s1.end_of_text);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			prev_q <= '0;
			cur_q  <= '0;
			pend_q <= '0;
			seq_q  <= '0;
			lead_q <= '0;
			have_q <= 1'b0;
			cnt_q  <= '0;
			err_q  <= ST_OK;
		end else if (go) begin
			if (word_s1.end_of_text) begin
				off_q  <= '0;
				prev_q <= '0;
				cur_q  <= '0;
				pend_q <= '0;
				seq_q  <= '0;
				lead_q <= '0;
				have_q <= 1'b0;
				cnt_q  <= '0;
				err_q  <= ST_OK;
			end else begin
				off_q  <= off_d;
				prev_q <= prev_d;
				cur_q  <= cur_d;
				pend_q <= pend_d;
				seq_q  <= seq_d;
				lead_q <= lead_d;
				have_q <= have_d;
				cnt_q  <= cnt_d;
				err_q  <= err_d;
			end
		end
	end

	`UBST_ASSERT(a_push_needs_room, clk, arst_n, (push.count != 2'd0) |-> room)
	`UBST_ASSERT(a_clear_after_last, clk, arst_n,
		(go && word_s1.end_of_text) |=> (off_q == '0 && err_q == ST_OK && !have_q))
	`UBST_ASSERT(a_error_sticky, clk, arst_n,
		(err_q != ST_OK && !(go && word_s1.end_of_text)) |=> (err_q == $past(err_q)))
	`UBST_ASSERT(a_no_token_after_error, clk, arst_n,
		(err_q != ST_OK) |-> !tok)

endmodule

/* design/ubst_queue.sv */
// Result queue that takes up to two words per cycle and hands out one while token_stall is low
`timescale 1ns / 1ps
`include "utf8_bigram_span_tokenizer_assert.svh"
module ubst_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ubst_pkg::push_t       push,
	input  ubst_pkg::token_word_t res0,
	input  ubst_pkg::token_word_t res1,
	output logic                  room,
	output logic                  token_valid,
	input  logic                  token_stall,
	output ubst_pkg::token_word_t token_word
);
	import ubst_pkg::*;

	token_word_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 pop;

	assign room        = count_q <= QCNT_BITS'(QUEUE_DEPTH - 2);
	assign token_valid = count_q != '0;
	assign token_word  = entry_q[rd_q];
	assign pop         = token_valid && !token_stall;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_q] <= res0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_q + QPTR_BITS'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_BITS'(push.count);
			rd_q    <= rd_q + QPTR_BITS'(pop);
			count_q <= count_q + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
		end
	end

	`UBST_ASSERT(a_count_bound, clk, arst_n, count_q <= QCNT_BITS'(QUEUE_DEPTH))
	`UBST_ASSERT(a_push_fits, clk, arst_n,
		(push.count != 2'd0) |-> (count_q <= QCNT_BITS'(QUEUE_DEPTH - 2)))
	`UBST_ASSERT(a_head_holds, clk, arst_n,
		(token_valid && token_stall) |=> (token_valid && $stable(token_word)))

endmodule

/* design/utf8_bigram_span_tokenizer.sv */
// Top level of the UTF-8 bigram span tokenizer
//
// The text channel (text_valid, text_stall, text_word) carries one byte of a
// UTF-8 text per word, with end_of_text set on the last byte of each text.
// The token channel (token_valid, token_stall, token_word) returns bigram
// tokens as code points complete, and one status word after the last byte of
// every text; final_item marks the last word that a text causes.
// A byte is taken into an input register, decoded against the running state
// in that cycle and its results written into a four-entry result queue.
// A token word passes the input register and then a queue entry before it is offered.
// One byte is accepted per cycle while the queue keeps room for two words;
// sustained rate is one word out per cycle while token_stall is low, so a byte
// that yields both a token and a status adds two words to the queue.
// Reset clears all text state and empties the queue. When the receiver
// stalls, the head word holds; once three words wait, a held byte raises text_stall.
// Tokens of a text whose status is not ok must be discarded by the receiver.
`timescale 1ns / 1ps
module utf8_bigram_span_tokenizer #(
	parameter int OFFSET_BITS = ubst_pkg::OFFSET_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_stall,
	input  ubst_pkg::text_word_t  text_word,
	output logic                  token_valid,
	input  logic                  token_stall,
	output ubst_pkg::token_word_t token_word
);
	import ubst_pkg::*;

	push_t       push;
	token_word_t res0, res1;
	logic        room;

	ubst_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_word  (text_word),
		.room       (room),
		.push       (push),
		.res0       (res0),
		.res1       (res1)
	);

	ubst_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.res0        (res0),
		.res1        (res1),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_word  (token_word)
	);

endmodule
